// File: sv/led_effect_frame_generator_top_defines.svh
// Assertion macros for the LED effect frame generator.
// Used by led_effect_frame_generator_top.sv; no other dependencies.
`ifndef LED_EFFECT_FRAME_GENERATOR_TOP_DEFINES_SVH
`define LED_EFFECT_FRAME_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define LEFG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lefg: same-cycle check failed");

// next-cycle implication
`define LEFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lefg: next-cycle check failed");

`endif

// File: sv/lefg_pkg.sv
// Shared types, codes and helpers of the LED effect frame generator.
// No dependencies.
package lefg_pkg;

   localparam int PIXEL_COUNT_DEF = 64;
   localparam int DESC_DEPTH      = 2;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_BREATH  = 2'd1,
      MODE_RAINBOW = 2'd2,
      MODE_BLINK   = 2'd3
   } mode_type;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_SET  = 1'b1
   } func_type;

   localparam logic [2:0] CSR_SATURATION = 3'd0;
   localparam logic [2:0] CSR_VALUE      = 3'd1;
   localparam logic [2:0] CSR_STEP       = 3'd2;
   localparam logic [2:0] CSR_RED_LEVEL  = 3'd3;
   localparam logic [2:0] CSR_TOGGLES    = 3'd4;

   localparam logic [7:0] WAIT_OFF     = 8'd100;
   localparam logic [7:0] WAIT_BREATH  = 8'd50;
   localparam logic [7:0] WAIT_RAINBOW = 8'd50;
   localparam logic [7:0] WAIT_BLINK   = 8'd200;

   // floor(50*(sin(k*pi/100)+1)), k = 0..50; mirrored about 50
   localparam logic [6:0] HALF_WAVE [0:50] = '{
      7'd50, 7'd51, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd60, 7'd62, 7'd63,
      7'd65, 7'd66, 7'd68, 7'd69, 7'd71, 7'd72, 7'd74, 7'd75, 7'd76, 7'd78,
      7'd79, 7'd80, 7'd81, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd88, 7'd89,
      7'd90, 7'd91, 7'd92, 7'd93, 7'd93, 7'd94, 7'd95, 7'd95, 7'd96, 7'd97,
      7'd97, 7'd98, 7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd100
   };

   // one frame job, handed from front to back
   typedef struct packed {
      mode_type   mode;
      logic [7:0] level;    // breath v or blink red
      logic [8:0] hue_off;
      logic [7:0] sat;
      logic [7:0] val;
   } desc_type;

   // per-pixel control carried down the render pipeline
   typedef struct packed {
      mode_type   mode;
      logic [7:0] level;
      logic [7:0] sat;
      logic [7:0] val;
      logic [5:0] idx;
      logic       last;
   } pix_ctl_type;

   typedef struct packed {
      logic busy;
   } back_stat_type;

   // exact floor(x/255) for x <= 255*255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return s[15:8];
   endfunction

endpackage

// File: sv/led_effect_frame_generator_top.sv
// LED strip animation frame generator.
// Channels: req_ is a queue input (push/full) carrying func and new_mode;
//   rsp_ is a queue output (empty/pop) carrying one pixel per item; csr_ is a
//   write-only register port (index 0 saturation, 1 value, 2 hue step,
//   3 blink red level, 4 blink toggles).
// A set-mode item only changes the mode and makes no result. A tick item
//   renders one frame: PIXEL_COUNT pixel items in strip order, the last one
//   flagged, each with the wait in ms of the mode that rendered it.
// A tick taken while the back end is idle passes through the job queue, the
//   pixel walker and the render pipeline to its first pixel. Throughput: one
//   pixel per cycle while the receiver keeps popping, set by the pixel walker.
// The front end takes an item per cycle until the two-entry job queue is
//   full; req_full mirrors the queue's full flag.
// When the receiver stops popping, the whole render pipeline holds in place;
//   the queue then fills and req_full rises. Nothing is dropped.
// Reset (synchronous, active high) restores register defaults, mode off,
//   all animation state to zero, and empties queue and pipeline at once.
// The user writes configuration only while no frame is in flight; not enforced.
// Depends on lefg_pkg, lefg_front, lefg_fifo, lefg_back and the defines header.
`include "led_effect_frame_generator_top_defines.svh"

module led_effect_frame_generator_top #(
   parameter int PIXEL_COUNT = lefg_pkg::PIXEL_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_func,
   input  logic [1:0] req_new_mode,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [8:0] csr_wdata,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [5:0] rsp_pixel_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_last_pixel,
   output logic [7:0] rsp_wait_ms
);
   import lefg_pkg::*;

   logic          desc_push, desc_pop, desc_empty, desc_full;
   desc_type      desc_wr, desc_rd;
   back_stat_type back_stat;

   assign req_full = desc_full;

   // front: classify items, step animation state, issue frame jobs
   lefg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_func     (req_func),
      .req_new_mode (req_new_mode),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .desc_full    (desc_full),
      .desc_push    (desc_push),
      .desc         (desc_wr)
   );

   // job queue decoupling the two halves
   lefg_fifo #(
      .DEPTH (DESC_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (desc_push),
      .wr_data (desc_wr),
      .pop     (desc_pop),
      .rd_data (desc_rd),
      .empty   (desc_empty),
      .full    (desc_full)
   );

   // back: per-pixel rendering
   lefg_back #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (desc_rd),
      .job_empty       (desc_empty),
      .job_pop         (desc_pop),
      .stat            (back_stat),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_wait_ms     (rsp_wait_ms)
   );

   // a taken tick always leaves a job queued for the back end
   `LEFG_ASSERT_NEXT(a_tick_queued, clock, reset, desc_push, !desc_empty)
   // the end-of-frame flag sits on the final strip position only
   `LEFG_ASSERT_NOW(a_last_index, clock, reset, !rsp_empty && rsp_last_pixel,
                    rsp_pixel_index == 6'(PIXEL_COUNT - 1))
   // reset leaves nothing in flight
   `LEFG_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, rsp_empty && !back_stat.busy && desc_empty)

endmodule

// File: sv/lefg_front.sv
// Front end: accepts items, holds mode, animation state and config registers,
// and turns each tick into a frame job. Depends on lefg_pkg.
module lefg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_func,
   input  logic [1:0]        req_new_mode,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [8:0]        csr_wdata,
   input  logic              desc_full,
   output logic              desc_push,
   output lefg_pkg::desc_type desc
);
   import lefg_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [6:0] level_ff, level_in;
   logic       falling_ff, falling_in;
   logic [8:0] hue_ff, hue_in;
   logic       blink_on_ff, blink_on_in;
   logic [3:0] frames_ff, frames_in;

   logic [7:0] sat_ff, val_ff, red_ff;
   logic [8:0] step_ff;
   logic [3:0] toggles_ff;

   logic       accept;
   logic [6:0] lvl_next;
   logic       fall_next;
   logic [5:0] wave_idx;
   logic [9:0] hue_sum;
   logic [8:0] hue_next;
   logic [3:0] frames_next;

   assign accept = req_push && !desc_full;

   always_comb begin
      // breath bounce
      if (falling_ff) begin
         if (level_ff <= 7'd1) begin
            lvl_next  = 7'd0;
            fall_next = 1'b0;
         end else begin
            lvl_next  = level_ff - 7'd1;
            fall_next = 1'b1;
         end
      end else begin
         if (level_ff + 7'd1 >= 7'd100) begin
            lvl_next  = 7'd100;
            fall_next = 1'b1;
         end else begin
            lvl_next  = level_ff + 7'd1;
            fall_next = 1'b0;
         end
      end
      wave_idx = (lvl_next <= 7'd50) ? lvl_next[5:0] : 6'(7'd100 - lvl_next);

      // hue offset advance, sum < 871
      hue_sum = {1'b0, hue_ff} + {1'b0, step_ff};
      priority if (hue_sum >= 10'd720) hue_next = 9'(hue_sum - 10'd720);
      else if (hue_sum >= 10'd360)     hue_next = 9'(hue_sum - 10'd360);
      else                             hue_next = hue_sum[8:0];

      frames_next = frames_ff + 4'd1;
   end

   always_comb begin
      mode_in     = mode_ff;
      level_in    = level_ff;
      falling_in  = falling_ff;
      hue_in      = hue_ff;
      blink_on_in = blink_on_ff;
      frames_in   = frames_ff;
      desc_push   = 1'b0;
      desc.mode    = mode_ff;
      desc.level   = 8'd0;
      desc.hue_off = hue_ff;
      desc.sat     = sat_ff;
      desc.val     = val_ff;

      if (accept) begin
         if (func_type'(req_func) == FUNC_SET) begin
            mode_in = mode_type'(req_new_mode);
         end else begin
            desc_push = 1'b1;
            unique case (mode_ff)
               MODE_OFF: begin
               end
               MODE_BREATH: begin
                  level_in   = lvl_next;
                  falling_in = fall_next;
                  desc.level = {1'b0, HALF_WAVE[wave_idx]};
               end
               MODE_RAINBOW: begin
                  hue_in = hue_next;
               end
               MODE_BLINK: begin
                  desc.level  = blink_on_ff ? red_ff : 8'd0;
                  blink_on_in = !blink_on_ff;
                  frames_in   = frames_next;
                  if (frames_next >= toggles_ff) begin
                     frames_in   = 4'd0;
                     blink_on_in = 1'b0;
                     mode_in     = MODE_BREATH;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         level_ff    <= 7'd0;
         falling_ff  <= 1'b0;
         hue_ff      <= 9'd0;
         blink_on_ff <= 1'b0;
         frames_ff   <= 4'd0;
      end else begin
         mode_ff     <= mode_in;
         level_ff    <= level_in;
         falling_ff  <= falling_in;
         hue_ff      <= hue_in;
         blink_on_ff <= blink_on_in;
         frames_ff   <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff     <= 8'd255;
         val_ff     <= 8'd100;
         step_ff    <= 9'd5;
         red_ff     <= 8'd150;
         toggles_ff <= 4'd6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SATURATION: sat_ff     <= csr_wdata[7:0];
            CSR_VALUE:      val_ff     <= csr_wdata[7:0];
            CSR_STEP:       step_ff    <= csr_wdata;
            CSR_RED_LEVEL:  red_ff     <= csr_wdata[7:0];
            CSR_TOGGLES:    toggles_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// File: sv/lefg_fifo.sv
// Short job queue between front and back ends.
// Depends on lefg_pkg for the job type.
module lefg_fifo #(
   parameter int DEPTH = lefg_pkg::DESC_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lefg_pkg::desc_type wr_data,
   input  logic               pop,
   output lefg_pkg::desc_type rd_data,
   output logic               empty,
   output logic               full
);
   import lefg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// File: sv/lefg_back.sv
// Back end: walks the pixels of one frame job and renders each through a
// six-stage color pipeline ending in the result register. Depends on lefg_pkg.
module lefg_back #(
   parameter int PIXEL_COUNT = lefg_pkg::PIXEL_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lefg_pkg::desc_type      job,
   input  logic                    job_empty,
   output logic                    job_pop,
   output lefg_pkg::back_stat_type stat,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic [5:0]              rsp_pixel_index,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic                    rsp_last_pixel,
   output logic [7:0]              rsp_wait_ms
);
   import lefg_pkg::*;

   localparam int Q_STEP = 360 / PIXEL_COUNT;
   localparam int R_STEP = 360 % PIXEL_COUNT;

   // pixel walker
   logic        busy_ff;
   desc_type    job_ff;
   logic [5:0]  idx_ff;
   logic [8:0]  q_ff;       // floor(idx*360/PIXEL_COUNT)
   logic [6:0]  rem_ff;
   logic [6:0]  rem_sum;
   logic        en, issue, is_last;
   pix_ctl_type c0;

   // pipeline
   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   pix_ctl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic [8:0]  hue1_ff;
   logic [2:0]  sec2_ff, sec3_ff, sec4_ff, sec5_ff;
   logic [7:0]  frac2_ff;
   logic [15:0] sf3_ff, sg3_ff, ps3_ff;
   logic [7:0]  a4_ff, b4_ff, p4_ff, p5_ff;
   logic [15:0] qm5_ff, tm5_ff;

   logic [9:0]  hue_raw;
   logic [8:0]  hue;
   logic [2:0]  sec;
   logic [8:0]  rem60;
   logic [9:0]  frac_x17;
   logic [7:0]  qv, tv;
   logic [7:0]  r_o, g_o, b_o, w_o;

   logic [5:0] idx_o_ff;
   logic [7:0] red_o_ff, green_o_ff, blue_o_ff, wait_o_ff;
   logic       last_o_ff;

   assign en      = !vo_ff || rsp_pop;
   assign issue   = busy_ff && en;
   assign is_last = (idx_ff == 6'(PIXEL_COUNT - 1));
   assign job_pop = !busy_ff && !job_empty;
   assign stat.busy = busy_ff;
   assign rem_sum = rem_ff + 7'(R_STEP);

   always_comb begin
      c0.mode  = job_ff.mode;
      c0.level = job_ff.level;
      c0.sat   = job_ff.sat;
      c0.val   = job_ff.val;
      c0.idx   = idx_ff;
      c0.last  = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (job_pop) begin
         busy_ff <= 1'b1;
      end else if (issue && is_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
         idx_ff <= 6'd0;
         q_ff   <= 9'd0;
         rem_ff <= 7'd0;
      end else if (issue) begin
         idx_ff <= idx_ff + 6'd1;
         if (rem_sum >= 7'(PIXEL_COUNT)) begin
            rem_ff <= rem_sum - 7'(PIXEL_COUNT);
            q_ff   <= q_ff + 9'(Q_STEP + 1);
         end else begin
            rem_ff <= rem_sum;
            q_ff   <= q_ff + 9'(Q_STEP);
         end
      end
   end

   // stage 1: hue; stage 2: sector and fraction
   always_comb begin
      hue_raw = {1'b0, q_ff} + {1'b0, job_ff.hue_off};
      hue     = (hue_raw >= 10'd360) ? 9'(hue_raw - 10'd360) : hue_raw[8:0];

      priority if (hue1_ff >= 9'd300) begin
         sec = 3'd5; rem60 = hue1_ff - 9'd300;
      end else if (hue1_ff >= 9'd240) begin
         sec = 3'd4; rem60 = hue1_ff - 9'd240;
      end else if (hue1_ff >= 9'd180) begin
         sec = 3'd3; rem60 = hue1_ff - 9'd180;
      end else if (hue1_ff >= 9'd120) begin
         sec = 3'd2; rem60 = hue1_ff - 9'd120;
      end else if (hue1_ff >= 9'd60) begin
         sec = 3'd1; rem60 = hue1_ff - 9'd60;
      end else begin
         sec = 3'd0; rem60 = hue1_ff;
      end
      // rem*255/60 == floor(rem*17/4)
      frac_x17 = 10'(rem60[5:0] * 10'd17);
   end

   // stage 6: final division and channel select
   always_comb begin
      qv = div255(qm5_ff);
      tv = div255(tm5_ff);
      r_o = 8'd0;
      g_o = 8'd0;
      b_o = 8'd0;
      w_o = WAIT_OFF;
      unique case (c5_ff.mode)
         MODE_OFF: begin
            w_o = WAIT_OFF;
         end
         MODE_BREATH: begin
            g_o = c5_ff.level;
            b_o = c5_ff.level;
            w_o = WAIT_BREATH;
         end
         MODE_RAINBOW: begin
            w_o = WAIT_RAINBOW;
            unique case (sec5_ff)
               3'd0: begin r_o = c5_ff.val; g_o = tv;        b_o = p5_ff;     end
               3'd1: begin r_o = qv;        g_o = c5_ff.val; b_o = p5_ff;     end
               3'd2: begin r_o = p5_ff;     g_o = c5_ff.val; b_o = tv;        end
               3'd3: begin r_o = p5_ff;     g_o = qv;        b_o = c5_ff.val; end
               3'd4: begin r_o = tv;        g_o = p5_ff;     b_o = c5_ff.val; end
               default: begin r_o = c5_ff.val; g_o = p5_ff;  b_o = qv;        end
            endcase
         end
         MODE_BLINK: begin
            r_o = c5_ff.level;
            w_o = WAIT_BLINK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= busy_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vo_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff   <= c0;
         hue1_ff <= hue;

         c2_ff    <= c1_ff;
         sec2_ff  <= sec;
         frac2_ff <= frac_x17[9:2];

         c3_ff   <= c2_ff;
         sec3_ff <= sec2_ff;
         sf3_ff  <= c2_ff.sat * frac2_ff;
         sg3_ff  <= c2_ff.sat * (8'd255 - frac2_ff);
         ps3_ff  <= c2_ff.val * (8'd255 - c2_ff.sat);

         c4_ff   <= c3_ff;
         sec4_ff <= sec3_ff;
         a4_ff   <= div255(sf3_ff);
         b4_ff   <= div255(sg3_ff);
         p4_ff   <= div255(ps3_ff);

         c5_ff   <= c4_ff;
         sec5_ff <= sec4_ff;
         p5_ff   <= p4_ff;
         qm5_ff  <= c4_ff.val * (8'd255 - a4_ff);
         tm5_ff  <= c4_ff.val * (8'd255 - b4_ff);

         idx_o_ff   <= c5_ff.idx;
         last_o_ff  <= c5_ff.last;
         red_o_ff   <= r_o;
         green_o_ff <= g_o;
         blue_o_ff  <= b_o;
         wait_o_ff  <= w_o;
      end
   end

   assign rsp_empty       = !vo_ff;
   assign rsp_pixel_index = idx_o_ff;
   assign rsp_red         = red_o_ff;
   assign rsp_green       = green_o_ff;
   assign rsp_blue        = blue_o_ff;
   assign rsp_last_pixel  = last_o_ff;
   assign rsp_wait_ms     = wait_o_ff;

endmodule

// File: test/led_effect_frame_generator_top_tb.sv
// Self-checking testbench for the LED effect frame generator: a directed table
// followed by randomized mode/tick traffic with random stalls on both queues.
// Depends on lefg_pkg and led_effect_frame_generator_top.
`timescale 1ns / 100ps

module led_effect_frame_generator_top_tb;
   import lefg_pkg::*;

   localparam int PIXELS       = PIXEL_COUNT_DEF;
   localparam int RESET_CYCLES = 10;
   localparam int QUIET_CYCLES = 32;       // longer than the render latency, lets set-mode items settle
   localparam int HOLD_CYCLES  = 400;      // long receiver hold-off, fills the job queue
   localparam int RANDOM_ITEMS = 445;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int MAX_REPORTS  = 40;

   // index past the register file; writes to it must change nothing
   localparam logic [2:0] CSR_SPARE = 3'd7;

   // floor(50*(sin(k*pi/100)+1)) for k = 0..50, mirrored about 50
   localparam logic [7:0] SINE_HALF [0:50] = '{
      8'd50, 8'd51, 8'd53, 8'd54, 8'd56, 8'd57, 8'd59, 8'd60, 8'd62, 8'd63,
      8'd65, 8'd66, 8'd68, 8'd69, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd78,
      8'd79, 8'd80, 8'd81, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88, 8'd89,
      8'd90, 8'd91, 8'd92, 8'd93, 8'd93, 8'd94, 8'd95, 8'd95, 8'd96, 8'd97,
      8'd97, 8'd98, 8'd98, 8'd98, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd100
   };

   typedef struct packed {
      logic [5:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
      logic [7:0] wait_ms;
   } strip_pixel_type;

   typedef enum logic { STEP_ITEM, STEP_CSR } step_kind_type;

   // one directed step; typed rows carry the whole-frame color and wait
   typedef struct packed {
      step_kind_type kind;
      func_type   func;
      mode_type   mode;
      logic [2:0] reg_idx;
      logic [8:0] reg_data;
      logic       typed;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] wait_ms;
   } plan_row_type;

   localparam int PLAN_ROWS = 33;
   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      // after reset: mode off, black, 100 ms; mode field ignored on a tick
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd0, 8'd0, WAIT_OFF},
      '{STEP_ITEM, FUNC_TICK, MODE_BLINK,   CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd0, 8'd0, WAIT_OFF},
      // breath climbs from level 0: first frames at levels 1 and 2
      '{STEP_ITEM, FUNC_SET,  MODE_BREATH,  CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd51, 8'd51,
        WAIT_BREATH},
      '{STEP_ITEM, FUNC_TICK, MODE_RAINBOW, CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd53, 8'd53,
        WAIT_BREATH},
      '{STEP_ITEM, FUNC_SET,  MODE_RAINBOW, CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // blink: black first, then red at the default level, back to breath after 6
      '{STEP_ITEM, FUNC_SET,  MODE_BLINK,   CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd0, 8'd0,
        WAIT_BLINK},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd150, 8'd0, 8'd0,
        WAIT_BLINK},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // back-to-back mode sets with no frame between them
      '{STEP_ITEM, FUNC_SET,  MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_SET,  MODE_RAINBOW, CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // saturation 0 / value 255: white rainbow; step 359; zero toggles
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_SATURATION, 9'h100, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_VALUE,      9'h0FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_STEP,       9'd359, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_RED_LEVEL,  9'h0FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_TOGGLES,    9'h1F0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_SPARE,      9'h1FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd255, 8'd255, 8'd255,
        WAIT_RAINBOW},
      '{STEP_ITEM, FUNC_SET,  MODE_BLINK,   CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd0, 8'd0,
        WAIT_BLINK},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // saturation 255 / value 0: black rainbow; step 511 wraps; toggles 15
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_SATURATION, 9'h0FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_VALUE,      9'h100, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_STEP,       9'h1FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_CSR,  FUNC_TICK, MODE_OFF,     CSR_TOGGLES,    9'h00F, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_SET,  MODE_RAINBOW, CSR_SPARE, 9'h000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{STEP_ITEM, FUNC_TICK, MODE_OFF,     CSR_SPARE, 9'h000, 1'b1, 8'd0, 8'd0, 8'd0,
        WAIT_RAINBOW}
   };

   // DUT ports, inputs known from time zero
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   func_type   req_func = FUNC_TICK;
   mode_type   req_new_mode = MODE_OFF;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = CSR_SPARE;
   logic [8:0] csr_wdata = 9'h000;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [5:0] rsp_pixel_index;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_last_pixel;
   logic [7:0] rsp_wait_ms;

   // predictor copy of the register file, reset values
   logic [7:0] cfg_sat     = 8'd255;
   logic [7:0] cfg_val     = 8'd100;
   logic [8:0] cfg_step    = 9'd5;
   logic [7:0] cfg_red     = 8'd150;
   logic [3:0] cfg_toggles = 4'd6;

   // predictor copy of the animation state
   mode_type   anim_mode   = MODE_OFF;
   logic [6:0] breath_lvl  = 7'd0;
   logic       breath_down = 1'b0;
   logic [8:0] hue_base    = 9'd0;
   logic       blink_lit   = 1'b0;
   logic [3:0] blink_count = 4'd0;

   strip_pixel_type frame_buf [PIXELS];
   int              frame_len;
   strip_pixel_type pending_pixels [$];

   int errors         = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int send_calm_left = 0;
   bit hold_request   = 1'b0;

   led_effect_frame_generator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_new_mode    (req_new_mode),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_wait_ms     (rsp_wait_ms)
   );

   always #4 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d pixels still pending", $time, pending_pixels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // integer HSV to RGB, packed {r, g, b}
   function automatic logic [23:0] wheel_rgb(input int hue, input int sat, input int val);
      int sector, frac, p, q, t;
      logic [7:0] r, g, b;
      sector = hue / 60;
      frac   = (hue % 60) * 255 / 60;
      p      = val * (255 - sat) / 255;
      q      = val * (255 - sat * frac / 255) / 255;
      t      = val * (255 - sat * (255 - frac) / 255) / 255;
      case (sector)
         0: begin r = 8'(val); g = 8'(t);   b = 8'(p);   end
         1: begin r = 8'(q);   g = 8'(val); b = 8'(p);   end
         2: begin r = 8'(p);   g = 8'(val); b = 8'(t);   end
         3: begin r = 8'(p);   g = 8'(q);   b = 8'(val); end
         4: begin r = 8'(t);   g = 8'(p);   b = 8'(val); end
         default: begin r = 8'(val); g = 8'(p); b = 8'(q); end
      endcase
      return {r, g, b};
   endfunction

   // advance the animation by one accepted item; frame lands in frame_buf
   task automatic run_predictor(input func_type f, input mode_type m);
      int i;
      mode_type   drawn;
      logic [7:0] r, g, b, w;
      logic [23:0] rgb;
      frame_len = 0;
      if (f == FUNC_SET) begin
         anim_mode = m;
         return;
      end
      drawn = anim_mode;
      r = 8'd0; g = 8'd0; b = 8'd0;
      case (drawn)
         MODE_OFF: w = WAIT_OFF;
         MODE_BREATH: begin
            // level bounces between 0 and 100, turning at either end
            if (breath_down) begin
               if (breath_lvl <= 1) begin
                  breath_lvl  = 7'd0;
                  breath_down = 1'b0;
               end else begin
                  breath_lvl = breath_lvl - 7'd1;
               end
            end else begin
               if (int'(breath_lvl) + 1 >= 100) begin
                  breath_lvl  = 7'd100;
                  breath_down = 1'b1;
               end else begin
                  breath_lvl = breath_lvl + 7'd1;
               end
            end
            g = SINE_HALF[breath_lvl <= 50 ? breath_lvl : 100 - breath_lvl];
            b = g;
            w = WAIT_BREATH;
         end
         MODE_RAINBOW: w = WAIT_RAINBOW;
         default: begin
            r = blink_lit ? cfg_red : 8'd0;
            w = WAIT_BLINK;
            blink_lit   = ~blink_lit;
            blink_count = blink_count + 4'd1;
            if (blink_count >= cfg_toggles) begin
               blink_count = 4'd0;
               blink_lit   = 1'b0;
               anim_mode   = MODE_BREATH;
            end
         end
      endcase
      for (i = 0; i < PIXELS; i++) begin
         if (drawn == MODE_RAINBOW) begin
            rgb = wheel_rgb((i * 360 / PIXELS + int'(hue_base)) % 360, cfg_sat, cfg_val);
            {r, g, b} = rgb;
         end
         frame_buf[i].idx     = 6'(i);
         frame_buf[i].red     = r;
         frame_buf[i].green   = g;
         frame_buf[i].blue    = b;
         frame_buf[i].last    = (i == PIXELS - 1);
         frame_buf[i].wait_ms = w;
      end
      if (drawn == MODE_RAINBOW)
         hue_base = 9'((int'(hue_base) + int'(cfg_step)) % 360);
      frame_len = PIXELS;
   endtask

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (send_calm_left > 0) begin
         send_calm_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 3) begin
         send_calm_left = $urandom_range(20, 60);
         return 0;
      end
      return idle_len();
   endfunction

   function automatic mode_type pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return MODE_OFF;
      if (r < 55) return MODE_BREATH;
      if (r < 80) return MODE_RAINBOW;
      return MODE_BLINK;
   endfunction

   // register value, extremes favored; bits above the register width are noise
   function automatic logic [8:0] reg_data(input int hi);
      int r, v;
      r = $urandom_range(0, 9);
      v = (r < 2) ? 0 : (r < 4) ? hi : $urandom_range(0, hi);
      return 9'(($urandom_range(0, 511) & ~hi) | v);
   endfunction

   // push one item; on acceptance queue the expected frame (typed look overrides color)
   task automatic send_item(input func_type f, input mode_type m,
                            input logic typed, input logic [31:0] look);
      int k, gap;
      strip_pixel_type px;
      req_func     <= f;
      req_new_mode <= m;
      req_push     <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      run_predictor(f, m);
      for (k = 0; k < frame_len; k++) begin
         px = frame_buf[k];
         if (typed) {px.red, px.green, px.blue, px.wait_ms} = look;
         pending_pixels.push_back(px);
      end
      gap = next_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending, let every expected pixel drain, then give trailing set items time
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SATURATION: cfg_sat     = data[7:0];
         CSR_VALUE:      cfg_val     = data[7:0];
         CSR_STEP:       cfg_step    = data;
         CSR_RED_LEVEL:  cfg_red     = data[7:0];
         CSR_TOGGLES:    cfg_toggles = data[3:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic shuffle_config();
      write_reg(CSR_SATURATION, reg_data(255));
      write_reg(CSR_VALUE,      reg_data(255));
      write_reg(CSR_STEP,       reg_data(511));
      write_reg(CSR_RED_LEVEL,  reg_data(255));
      write_reg(CSR_TOGGLES,    reg_data(15));
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_SPARE, 9'($urandom_range(0, 511)));
   endtask

   task automatic match_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_pixel();
      strip_pixel_type want;
      if (pending_pixels.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: pixel %0d arrived with no frame pending, expected none",
                     $time, rsp_pixel_index);
      end else begin
         want = pending_pixels.pop_front();
         match_field("pixel_index", want.idx,     rsp_pixel_index);
         match_field("red",         want.red,     rsp_red);
         match_field("green",       want.green,   rsp_green);
         match_field("blue",        want.blue,    rsp_blue);
         match_field("last_pixel",  want.last,    rsp_last_pixel);
         match_field("wait_ms",     want.wait_ms, rsp_wait_ms);
      end
   endtask

   // pixel receiver: random stalls, calm stretches, and one long hold-off on request
   initial begin : pixel_sink
      int stall_left;
      int calm_left;
      int hold_left;
      stall_left = 0;
      calm_left  = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_pixel();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 99) < 3)
               calm_left = $urandom_range(50, 300);
            else
               stall_left = idle_len();
         end
      end
   end

   initial begin : stimulus
      int row, sent, next_cfg, ticks;
      mode_type m;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (row = 0; row < PLAN_ROWS; row++) begin
         if (PLAN[row].kind == STEP_CSR) begin
            wait_idle();
            write_reg(PLAN[row].reg_idx, PLAN[row].reg_data);
         end else begin
            send_item(PLAN[row].func, PLAN[row].mode, PLAN[row].typed,
                      {PLAN[row].red, PLAN[row].green, PLAN[row].blue, PLAN[row].wait_ms});
         end
      end

      // back-pressure: receiver holds off while a burst of ticks fills the queue
      wait_idle();
      hold_request = 1'b1;
      burst_left   = 14;
      send_item(FUNC_SET, MODE_RAINBOW, 1'b0, '0);
      repeat (13) send_item(FUNC_TICK, mode_type'($urandom_range(0, 3)), 1'b0, '0);
      sent     = 14;
      next_cfg = sent + $urandom_range(20, 40);

      // random sessions: a mode set followed by a run of ticks, plus some noise
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_cfg) begin
            wait_idle();
            shuffle_config();
            next_cfg = sent + $urandom_range(60, 110);
         end
         if ($urandom_range(0, 99) < 85) begin
            m = pick_mode();
            send_item(FUNC_SET, m, 1'b0, '0);
            sent++;
            ticks = (m == MODE_BREATH) ? $urandom_range(3, 30) : $urandom_range(1, 10);
            repeat (ticks) begin
               send_item(FUNC_TICK, mode_type'($urandom_range(0, 3)), 1'b0, '0);
               sent++;
            end
         end else begin
            send_item(func_type'($urandom_range(0, 1)), mode_type'($urandom_range(0, 3)),
                      1'b0, '0);
            sent++;
         end
      end

      wait_idle();
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
